// ===== src/aabbcp_pkg.sv =====
// Shared types and constants for the box closest-point pipeline.
`timescale 1ns / 1ps
`default_nettype none

package aabbcp_pkg;

    // Fraction bits of the fixed-point coordinate format
    localparam int FRAC_BITS = 16;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOWER_X = 3'd0,
        REG_LOWER_Y = 3'd1,
        REG_LOWER_Z = 3'd2,
        REG_UPPER_X = 3'd3,
        REG_UPPER_Y = 3'd4,
        REG_UPPER_Z = 3'd5
    } t_cfg_reg;

    // Face normal codes, in tie-break order
    typedef enum logic [2:0] {
        FACE_PX = 3'd0,
        FACE_PY = 3'd1,
        FACE_PZ = 3'd2,
        FACE_NX = 3'd3,
        FACE_NY = 3'd4,
        FACE_NZ = 3'd5
    } t_face;

    localparam t_face FACE_ORDER [6] = '{FACE_PX, FACE_PY, FACE_PZ, FACE_NX, FACE_NY, FACE_NZ};
    localparam t_face FACE_POS [3] = '{FACE_PX, FACE_PY, FACE_PZ};
    localparam t_face FACE_NEG [3] = '{FACE_NX, FACE_NY, FACE_NZ};

    // Per-stage control that travels with each request
    typedef struct packed {
        logic valid;
        logic in_box;
    } t_ctl;

endpackage

`default_nettype wire

// ===== src/aabb_closest_point_normal.sv =====
// Top level: closest point on an axis-aligned box and the chosen face normal.
`timescale 1ns / 1ps
`default_nettype none

// Five-stage pipeline, one request per cycle while the output is not stalled.
// A request moves through the stage registers in order and its result is
// offered from the stage 5 output register. Stage 1 tests the
// point against the box and clamps each axis; stage 2 forms one signed key per
// face (minus the face distance for a point inside, the signed offset from the
// clamped point for one outside); stages 3 and 4 run a registered argmax tree
// over the six keys; stage 5 picks the face and snaps the point onto it. Every
// stage has its own valid bit and moves whenever its successor has room, so a
// stalled output only holds back the input once all five stages are full, and
// bubbles are squeezed out. Ties go to the earlier face in the order +x, +y,
// +z, -x, -y, -z. Coordinates are signed fixed point with 16 fraction bits;
// results are exact copies of input or box coordinates, no rounding. The box
// corners reset to (0,0,0) and (1,1,1) and may be rewritten only while no
// request is in flight; writes to an index past the six registers are dropped.
module aabb_closest_point_normal #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic [aabbcp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                i_cfg_data,
    // query request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]         i_point_x,
    input  logic signed [COORD_WIDTH-1:0]         i_point_y,
    input  logic signed [COORD_WIDTH-1:0]         i_point_z,
    // result request channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [COORD_WIDTH-1:0]         o_near_x,
    output logic signed [COORD_WIDTH-1:0]         o_near_y,
    output logic signed [COORD_WIDTH-1:0]         o_near_z,
    output logic [2:0]                            o_face_normal,
    output logic                                  o_was_inside
);

    // 1.0 in the coordinate format
    localparam logic signed [COORD_WIDTH-1:0] UPPER_RESET =
        COORD_WIDTH'(64'd1 << aabbcp_pkg::FRAC_BITS);

    // box corners, index 0..2 = x, y, z
    logic signed [COORD_WIDTH-1:0] r_lower [3];
    logic signed [COORD_WIDTH-1:0] r_upper [3];

    logic signed [COORD_WIDTH-1:0] w_point [3];

    // stage 1 -> stage 2
    aabbcp_pkg::t_ctl              w_s1_ctl;
    logic                          w_s1_ready;
    logic signed [COORD_WIDTH-1:0] w_s1_point [3];
    logic signed [COORD_WIDTH-1:0] w_s1_clamp [3];

    // stage 2 -> stage 3
    aabbcp_pkg::t_ctl              w_s2_ctl;
    logic                          w_s2_ready;
    logic signed [COORD_WIDTH:0]   w_s2_key [6];
    logic signed [COORD_WIDTH-1:0] w_s2_clamp [3];

    // stage 3 ready, and the output register
    logic                          w_s3_ready;
    aabbcp_pkg::t_ctl              w_out_ctl;
    logic signed [COORD_WIDTH-1:0] w_out_near [3];
    aabbcp_pkg::t_face             w_out_face;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '{'0, '0, '0};
            r_upper <= '{UPPER_RESET, UPPER_RESET, UPPER_RESET};
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                aabbcp_pkg::REG_LOWER_X: r_lower[0] <= i_cfg_data;
                aabbcp_pkg::REG_LOWER_Y: r_lower[1] <= i_cfg_data;
                aabbcp_pkg::REG_LOWER_Z: r_lower[2] <= i_cfg_data;
                aabbcp_pkg::REG_UPPER_X: r_upper[0] <= i_cfg_data;
                aabbcp_pkg::REG_UPPER_Y: r_upper[1] <= i_cfg_data;
                aabbcp_pkg::REG_UPPER_Z: r_upper[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_point[0] = i_point_x;
    assign w_point[1] = i_point_y;
    assign w_point[2] = i_point_z;

    aabbcp_clamp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (w_s1_ready),
        .i_point (w_point),
        .i_lower (r_lower),
        .i_upper (r_upper),
        .o_ctl   (w_s1_ctl),
        .i_ready (w_s2_ready),
        .o_point (w_s1_point),
        .o_clamp (w_s1_clamp)
    );

    aabbcp_keys #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_keys (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_s1_ctl),
        .o_ready (w_s2_ready),
        .i_point (w_s1_point),
        .i_clamp (w_s1_clamp),
        .i_lower (r_lower),
        .i_upper (r_upper),
        .o_ctl   (w_s2_ctl),
        .i_ready (w_s3_ready),
        .o_key   (w_s2_key),
        .o_clamp (w_s2_clamp)
    );

    aabbcp_select #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_s2_ctl),
        .o_ready (w_s3_ready),
        .i_key   (w_s2_key),
        .i_clamp (w_s2_clamp),
        .i_lower (r_lower),
        .i_upper (r_upper),
        .o_ctl   (w_out_ctl),
        .i_ready (!i_out_stall),
        .o_near  (w_out_near),
        .o_face  (w_out_face)
    );

    // stall the input only when stage 1 cannot take a request
    assign o_in_stall    = !w_s1_ready;
    assign o_out_valid   = w_out_ctl.valid;
    assign o_was_inside  = w_out_ctl.in_box;
    assign o_near_x      = w_out_near[0];
    assign o_near_y      = w_out_near[1];
    assign o_near_z      = w_out_near[2];
    assign o_face_normal = w_out_face;

endmodule

`default_nettype wire

// ===== src/aabbcp_clamp.sv =====
// Stage 1: box containment test and per-axis clamp of the query point.
`timescale 1ns / 1ps
`default_nettype none

module aabbcp_clamp #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point [3],
    input  logic signed [COORD_WIDTH-1:0] i_lower [3],
    input  logic signed [COORD_WIDTH-1:0] i_upper [3],
    output aabbcp_pkg::t_ctl              o_ctl,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_point [3],
    output logic signed [COORD_WIDTH-1:0] o_clamp [3]
);

    logic [2:0]                    w_below;
    logic [2:0]                    w_above;
    logic                          n_in_box;
    logic signed [COORD_WIDTH-1:0] n_clamp [3];

    aabbcp_pkg::t_ctl              r_ctl;
    logic signed [COORD_WIDTH-1:0] r_point [3];
    logic signed [COORD_WIDTH-1:0] r_clamp [3];

    // Raise to lower, then lower to upper: on an inverted axis upper wins
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_below[i] = i_point[i] < i_lower[i];
            w_above[i] = i_upper[i] < i_point[i];
            if (w_below[i]) begin
                n_clamp[i] = (i_upper[i] < i_lower[i]) ? i_upper[i] : i_lower[i];
            end else begin
                n_clamp[i] = w_above[i] ? i_upper[i] : i_point[i];
            end
        end
        n_in_box = ~|(w_below | w_above);
    end

    assign o_ready = !r_ctl.valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl.valid  <= i_valid;
            r_ctl.in_box <= n_in_box;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_point <= i_point;
            r_clamp <= n_clamp;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_point = r_point;
    assign o_clamp = r_clamp;

endmodule

`default_nettype wire

// ===== src/aabbcp_keys.sv =====
// Stage 2: six signed face keys, one per face, largest key wins.
`timescale 1ns / 1ps
`default_nettype none

module aabbcp_keys #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  aabbcp_pkg::t_ctl              i_ctl,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point [3],
    input  logic signed [COORD_WIDTH-1:0] i_clamp [3],
    input  logic signed [COORD_WIDTH-1:0] i_lower [3],
    input  logic signed [COORD_WIDTH-1:0] i_upper [3],
    output aabbcp_pkg::t_ctl              o_ctl,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH:0]   o_key [6],
    output logic signed [COORD_WIDTH-1:0] o_clamp [3]
);

    localparam int KW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] w_ref_hi [3];
    logic signed [COORD_WIDTH-1:0] w_ref_lo [3];
    logic signed [KW-1:0]          n_key [6];

    aabbcp_pkg::t_ctl              r_ctl;
    logic signed [KW-1:0]          r_key [6];
    logic signed [COORD_WIDTH-1:0] r_clamp [3];

    // Inside: key = -(distance to face). Outside: key = +/-(point - clamp).
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ref_hi[i] = i_ctl.in_box ? i_upper[i] : i_clamp[i];
            w_ref_lo[i] = i_ctl.in_box ? i_lower[i] : i_clamp[i];
            n_key[i]     = KW'(i_point[i]) - KW'(w_ref_hi[i]);
            n_key[i + 3] = KW'(w_ref_lo[i]) - KW'(i_point[i]);
        end
    end

    assign o_ready = !r_ctl.valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_key   <= n_key;
            r_clamp <= i_clamp;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_key   = r_key;
    assign o_clamp = r_clamp;

endmodule

`default_nettype wire

// ===== src/aabbcp_select.sv =====
// Stages 3-5: registered argmax tree over the face keys and final point mux.
`timescale 1ns / 1ps
`default_nettype none

module aabbcp_select #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  aabbcp_pkg::t_ctl              i_ctl,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH:0]   i_key [6],
    input  logic signed [COORD_WIDTH-1:0] i_clamp [3],
    input  logic signed [COORD_WIDTH-1:0] i_lower [3],
    input  logic signed [COORD_WIDTH-1:0] i_upper [3],
    output aabbcp_pkg::t_ctl              o_ctl,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_near [3],
    output aabbcp_pkg::t_face             o_face
);

    localparam int KW = COORD_WIDTH + 1;

    // Tree: pairs (0,1) (2,3) (4,5), then (01,23), then (0123,45).
    // Later entry wins only when strictly greater, so the first wins a tie.

    // Stage 3 - pair winners
    logic [2:0]                    w_c_pick;
    logic signed [KW-1:0]          n_c_key [3];
    aabbcp_pkg::t_face             n_c_face [3];
    aabbcp_pkg::t_ctl              r_c_ctl;
    logic signed [KW-1:0]          r_c_key [3];
    aabbcp_pkg::t_face             r_c_face [3];
    logic signed [COORD_WIDTH-1:0] r_c_clamp [3];
    logic                          w_c_ready;

    // Stage 4 - first four faces merged, pair (4,5) carried
    logic                          w_d_pick;
    aabbcp_pkg::t_ctl              r_d_ctl;
    logic signed [KW-1:0]          r_d_key;
    aabbcp_pkg::t_face             r_d_face;
    logic signed [KW-1:0]          r_d_key2;
    aabbcp_pkg::t_face             r_d_face2;
    logic signed [COORD_WIDTH-1:0] r_d_clamp [3];
    logic                          w_d_ready;

    // Stage 5 - output register
    logic                          w_e_pick;
    aabbcp_pkg::t_face             n_e_face;
    logic signed [COORD_WIDTH-1:0] n_e_near [3];
    aabbcp_pkg::t_ctl              r_e_ctl;
    aabbcp_pkg::t_face             r_e_face;
    logic signed [COORD_WIDTH-1:0] r_e_near [3];
    logic                          w_e_ready;

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            w_c_pick[g] = i_key[2 * g + 1] > i_key[2 * g];
            n_c_key[g]  = w_c_pick[g] ? i_key[2 * g + 1] : i_key[2 * g];
            n_c_face[g] = w_c_pick[g] ? aabbcp_pkg::FACE_ORDER[2 * g + 1]
                                      : aabbcp_pkg::FACE_ORDER[2 * g];
        end
    end

    assign w_d_pick = r_c_key[1] > r_c_key[0];
    assign w_e_pick = r_d_key2 > r_d_key;
    assign n_e_face = w_e_pick ? r_d_face2 : r_d_face;

    // Inside: the winning face's axis snaps to that face's plane
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_d_ctl.in_box && n_e_face == aabbcp_pkg::FACE_POS[i]) begin
                n_e_near[i] = i_upper[i];
            end else if (r_d_ctl.in_box && n_e_face == aabbcp_pkg::FACE_NEG[i]) begin
                n_e_near[i] = i_lower[i];
            end else begin
                n_e_near[i] = r_d_clamp[i];
            end
        end
    end

    assign w_e_ready = !r_e_ctl.valid || i_ready;
    assign w_d_ready = !r_d_ctl.valid || w_e_ready;
    assign w_c_ready = !r_c_ctl.valid || w_d_ready;
    assign o_ready   = w_c_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
            r_d_ctl <= '0;
            r_e_ctl <= '0;
        end else begin
            if (w_c_ready) begin
                r_c_ctl <= i_ctl;
            end
            if (w_d_ready) begin
                r_d_ctl <= r_c_ctl;
            end
            if (w_e_ready) begin
                r_e_ctl <= r_d_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ready && i_ctl.valid) begin
            r_c_key   <= n_c_key;
            r_c_face  <= n_c_face;
            r_c_clamp <= i_clamp;
        end
        if (w_d_ready && r_c_ctl.valid) begin
            r_d_key   <= w_d_pick ? r_c_key[1] : r_c_key[0];
            r_d_face  <= w_d_pick ? r_c_face[1] : r_c_face[0];
            r_d_key2  <= r_c_key[2];
            r_d_face2 <= r_c_face[2];
            r_d_clamp <= r_c_clamp;
        end
        if (w_e_ready && r_d_ctl.valid) begin
            r_e_face <= n_e_face;
            r_e_near <= n_e_near;
        end
    end

    assign o_ctl  = r_e_ctl;
    assign o_near = r_e_near;
    assign o_face = r_e_face;

endmodule

`default_nettype wire

// ===== src/aabbcp_checker.sv =====
// Port-level checks for the box closest-point block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module aabbcp_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [COORD_WIDTH-1:0] o_near_x,
    input logic signed [COORD_WIDTH-1:0] o_near_y,
    input logic signed [COORD_WIDTH-1:0] o_near_z,
    input logic [2:0]                    o_face_normal,
    input logic                          o_was_inside
);

    // a held result stays offered
    a_out_valid_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
    ) else $error("result dropped while stalled");

    // a held result does not change
    a_out_payload_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_near_x) && $stable(o_near_y) && $stable(o_near_z) &&
            $stable(o_face_normal) && $stable(o_was_inside)
    ) else $error("result changed while stalled");

    // only six face codes exist
    a_face_code: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_face_normal <= aabbcp_pkg::FACE_NZ
    ) else $error("face code out of range");

    // input back-pressure only when a full pipe is blocked at the output
    a_stall_cause: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall
    ) else $error("input stalled with room in the pipe");

endmodule

bind aabb_closest_point_normal aabbcp_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_aabbcp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_near_x      (o_near_x),
    .o_near_y      (o_near_y),
    .o_near_z      (o_near_z),
    .o_face_normal (o_face_normal),
    .o_was_inside  (o_was_inside)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for aabb_closest_point_normal: predicts each result, random traffic.
`timescale 1ns / 1ps

module tb_top;

    localparam int COORD_W      = 32;
    localparam int CLK_HALF     = 6;
    localparam int PIPE_DEPTH   = 5;      // pipeline stages, per the block header
    localparam int IDLE_LIMIT   = 3000;   // cycles with no request moving on either side
    localparam int MAX_PRINTED  = 20;
    localparam int HOLD_CYCLES  = 150;
    localparam int BOXES_PER_PHASE = 4;
    localparam int QUERIES_PER_BOX = 60;
    localparam int CIW = aabbcp_pkg::CFG_INDEX_W;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] ONE    = COORD_W'(1 << aabbcp_pkg::FRAC_BITS);
    localparam logic signed [COORD_W-1:0] HALF   = ONE >>> 1;
    localparam logic signed [COORD_W-1:0] EIGHTH = ONE >>> 3;

    // indexes past the six box registers; writes there must be dropped
    localparam logic [CIW-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CIW-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_query;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        aabbcp_pkg::t_face         face;
        logic                      in_box;
    } t_near;

    // ---------------------------------------------------------------------
    // DUT ports, inputs all known from time zero
    // ---------------------------------------------------------------------
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [CIW-1:0]              i_cfg_index = '0;
    logic [COORD_W-1:0]          i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [COORD_W-1:0]   i_point_x = '0;
    logic signed [COORD_W-1:0]   i_point_y = '0;
    logic signed [COORD_W-1:0]   i_point_z = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [COORD_W-1:0]   o_near_x;
    logic signed [COORD_W-1:0]   o_near_y;
    logic signed [COORD_W-1:0]   o_near_z;
    logic [2:0]                  o_face_normal;
    logic                        o_was_inside;

    aabb_closest_point_normal #(
        .COORD_WIDTH(COORD_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_near_x      (o_near_x),
        .o_near_y      (o_near_y),
        .o_near_z      (o_near_z),
        .o_face_normal (o_face_normal),
        .o_was_inside  (o_was_inside)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Testbench state
    // ---------------------------------------------------------------------
    logic signed [COORD_W-1:0] box_lo [3];   // shadow copy of the box registers
    logic signed [COORD_W-1:0] box_hi [3];
    t_near  pending_near [$];                // results owed by the DUT, oldest first
    t_near  want;
    int     send_idle_pct = 0;               // chance per cycle that the sender idles
    int     stall_pct = 0;                   // chance per cycle that the receiver stalls
    int     out_hold_len = 0;                // request for a long receiver hold-off
    int     error_count = 0;
    int     sent_count = 0;
    int     got_count = 0;
    int     box_count = 0;
    int     in_stall_cycles = 0;
    int     quiet_cycles = 0;

    // ---------------------------------------------------------------------
    // Predictor: nearest surface point and face normal for the shadow box
    // ---------------------------------------------------------------------
    function automatic t_near nearest_on_box(t_query q);
        logic signed [COORD_W-1:0] p [3];
        logic signed [COORD_W-1:0] c [3];
        logic signed [COORD_W+1:0] key [6];   // two spare bits: no overflow possible
        logic signed [COORD_W+1:0] wide_p, wide_c, wide_lo, wide_hi, best;
        logic  in_box;
        int    pick;
        int    i;
        t_near r;

        p[0] = q.x;
        p[1] = q.y;
        p[2] = q.z;
        in_box = 1'b1;
        for (i = 0; i < 3; i++) begin
            if (p[i] < box_lo[i] || p[i] > box_hi[i]) in_box = 1'b0;
        end

        pick = 0;
        if (in_box) begin
            // keys are distances to each face; smallest wins, earliest on a tie
            for (i = 0; i < 3; i++) begin
                c[i]    = p[i];
                wide_p  = p[i];
                wide_lo = box_lo[i];
                wide_hi = box_hi[i];
                key[i]     = wide_hi - wide_p;
                key[i + 3] = wide_p - wide_lo;
            end
            best = key[0];
            for (i = 1; i < 6; i++) begin
                if (key[i] < best) begin
                    best = key[i];
                    pick = i;
                end
            end
            if (pick < 3) c[pick] = box_hi[pick];
            else c[pick - 3] = box_lo[pick - 3];
        end else begin
            // raise to the lower corner, then lower to the upper one (upper wins
            // on an inverted axis); keys are signed offsets along each normal
            for (i = 0; i < 3; i++) begin
                c[i] = (p[i] < box_lo[i]) ? box_lo[i] : p[i];
                if (box_hi[i] < c[i]) c[i] = box_hi[i];
                wide_p = p[i];
                wide_c = c[i];
                key[i]     = wide_p - wide_c;
                key[i + 3] = wide_c - wide_p;
            end
            best = key[0];
            for (i = 1; i < 6; i++) begin
                if (key[i] > best) begin
                    best = key[i];
                    pick = i;
                end
            end
        end

        r.x      = c[0];
        r.y      = c[1];
        r.z      = c[2];
        r.face   = aabbcp_pkg::FACE_ORDER[pick];
        r.in_box = in_box;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ---------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [COORD_W-1:0] got,
                                   logic [COORD_W-1:0] exp_val);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR @%0t result %0d %s: got %h, expected %h",
                     $time, got_count, what, got, exp_val);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_near.size() == 0) begin
                report_mismatch("result with no request pending", '0, '0);
            end else begin
                want = pending_near.pop_front();
                if (o_near_x !== want.x) report_mismatch("near_x", o_near_x, want.x);
                if (o_near_y !== want.y) report_mismatch("near_y", o_near_y, want.y);
                if (o_near_z !== want.z) report_mismatch("near_z", o_near_z, want.z);
                if (o_face_normal !== want.face)
                    report_mismatch("face_normal", o_face_normal, want.face);
                if (o_was_inside !== want.in_box)
                    report_mismatch("was_inside", o_was_inside, want.in_box);
            end
            got_count++;
        end
        if (i_rst_n && i_in_valid && o_in_stall) in_stall_cycles++;
    end

    // Watchdog: a run where no request moves for too long is hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, or one long hold-off counted here when requested.
    initial begin : receiver
        int held;
        forever begin
            @(posedge i_clk);
            if (out_hold_len > 0) begin
                held = out_hold_len;
                out_hold_len = 0;
                i_out_stall <= 1'b1;
                repeat (held - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers (all entered right after a rising edge)
    // ---------------------------------------------------------------------
    function automatic t_query query_at(logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y,
                                        logic signed [COORD_W-1:0] z);
        t_query q;
        q.x = x;
        q.y = y;
        q.z = z;
        return q;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v < longint'(COORD_MIN)) return COORD_MIN;
        if (v > longint'(COORD_MAX)) return COORD_MAX;
        return v[COORD_W-1:0];
    endfunction

    // One request: optional idle cycles, then hold valid until accepted.
    task automatic send_point(t_query q);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_point_x  <= q.x;
        i_point_y  <= q.y;
        i_point_z  <= q.z;
        do @(posedge i_clk); while (o_in_stall);
        pending_near.push_back(nearest_on_box(q));
        sent_count++;
    endtask

    // Box registers may only change with nothing in flight.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_near.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CIW-1:0] idx, logic signed [COORD_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            aabbcp_pkg::REG_LOWER_X: box_lo[0] = value;
            aabbcp_pkg::REG_LOWER_Y: box_lo[1] = value;
            aabbcp_pkg::REG_LOWER_Z: box_lo[2] = value;
            aabbcp_pkg::REG_UPPER_X: box_hi[0] = value;
            aabbcp_pkg::REG_UPPER_Y: box_hi[1] = value;
            aabbcp_pkg::REG_UPPER_Z: box_hi[2] = value;
            default: ;   // spare index, dropped
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_box(logic signed [COORD_W-1:0] lx, logic signed [COORD_W-1:0] ly,
                           logic signed [COORD_W-1:0] lz, logic signed [COORD_W-1:0] ux,
                           logic signed [COORD_W-1:0] uy, logic signed [COORD_W-1:0] uz);
        cfg_write(aabbcp_pkg::REG_LOWER_X, lx);
        cfg_write(aabbcp_pkg::REG_LOWER_Y, ly);
        cfg_write(aabbcp_pkg::REG_LOWER_Z, lz);
        cfg_write(aabbcp_pkg::REG_UPPER_X, ux);
        cfg_write(aabbcp_pkg::REG_UPPER_Y, uy);
        cfg_write(aabbcp_pkg::REG_UPPER_Z, uz);
        box_count++;
    endtask

    // Random box: half modest or tiny ones (tiny boxes make ties common),
    // with wide, flat, inverted and full-range axes mixed in.
    task automatic random_box();
        logic signed [COORD_W-1:0] lo [3];
        logic signed [COORD_W-1:0] hi [3];
        logic signed [COORD_W-1:0] a, b;
        longint ctr;
        int kind;
        int i;
        kind = $urandom_range(0, 9);
        for (i = 0; i < 3; i++) begin
            a = $urandom;
            b = $urandom;
            case (kind)
                0, 1, 2: begin
                    ctr   = longint'($urandom_range(0, 32 * ONE)) - 16 * ONE;
                    lo[i] = clamp_coord(ctr);
                    hi[i] = clamp_coord(ctr + $urandom_range(0, 4 * ONE));
                end
                3, 4: begin
                    ctr   = longint'($urandom_range(0, 8)) - 4;
                    lo[i] = clamp_coord(ctr);
                    hi[i] = clamp_coord(ctr + $urandom_range(0, 6));
                end
                5: begin
                    lo[i] = (a < b) ? a : b;
                    hi[i] = (a < b) ? b : a;
                end
                6: begin
                    lo[i] = a >>> 8;
                    hi[i] = a >>> 8;
                end
                7: begin
                    // some axes inverted
                    lo[i] = ($urandom_range(0, 1) ^ (a < b)) ? a : b;
                    hi[i] = (lo[i] == a) ? b : a;
                end
                8: begin
                    lo[i] = COORD_MIN;
                    hi[i] = COORD_MAX;
                end
                default: begin
                    lo[i] = $urandom_range(0, 1) ? COORD_MIN : (a >>> 4);
                    hi[i] = (lo[i] == COORD_MIN) ? (b >>> 4) : COORD_MAX;
                end
            endcase
        end
        set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endtask

    // Random query shaped around the current box: half are fully inside
    // (some on a face), the rest mix inside, edges, just outside and the rails.
    function automatic t_query random_query();
        logic signed [COORD_W-1:0] p [3];
        longint lo, hi, v;
        logic   all_in;
        int     mode;
        int     i;
        all_in = ($urandom_range(0, 99) < 50);
        for (i = 0; i < 3; i++) begin
            lo = box_lo[i];
            hi = box_hi[i];
            if (lo > hi) begin
                v  = lo;
                lo = hi;
                hi = v;
            end
            mode = all_in ? $urandom_range(0, 2) : $urandom_range(0, 9);
            case (mode)
                2: v = $urandom_range(0, 1) ? lo : hi;
                3: v = lo - longint'($urandom_range(1, 3 * ONE));
                4: v = hi + longint'($urandom_range(1, 3 * ONE));
                5: v = lo + longint'($urandom_range(0, 2)) - 1;
                6: v = hi + longint'($urandom_range(0, 2)) - 1;
                7: v = longint'($signed($urandom));
                8: v = $urandom_range(0, 1) ? longint'(COORD_MIN) : longint'(COORD_MAX);
                default: v = lo + (longint'({$urandom, $urandom} >> 1) % (hi - lo + 1));
            endcase
            p[i] = clamp_coord(v);
        end
        return query_at(p[0], p[1], p[2]);
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Unit box from reset: each face from inside and outside, ties, rails.
    task automatic test_reset_box();
        wait_drained();
        send_point(query_at(HALF, HALF, HALF));                 // six-way tie -> +x
        send_point(query_at(ONE - EIGHTH, HALF, HALF));
        send_point(query_at(HALF, ONE - EIGHTH, HALF));
        send_point(query_at(HALF, HALF, ONE - EIGHTH));
        send_point(query_at(EIGHTH, HALF, HALF));
        send_point(query_at(HALF, EIGHTH, HALF));
        send_point(query_at(HALF, HALF, EIGHTH));
        send_point(query_at(ONE, ONE, ONE));                    // on the corner
        send_point(query_at(0, 0, 0));
        send_point(query_at(2 * ONE, HALF, HALF));              // outside, one per face
        send_point(query_at(HALF, 2 * ONE, HALF));
        send_point(query_at(HALF, HALF, 2 * ONE));
        send_point(query_at(-ONE, HALF, HALF));
        send_point(query_at(HALF, -ONE, HALF));
        send_point(query_at(HALF, HALF, -ONE));
        send_point(query_at(2 * ONE, 2 * ONE, 2 * ONE));        // outside ties
        send_point(query_at(-ONE, -ONE, -ONE));
        send_point(query_at(COORD_MIN, COORD_MAX, 0));
    endtask

    // Full-range box, dropped spare writes, flat box and inverted box.
    task automatic test_box_extremes();
        wait_drained();
        set_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(query_at(COORD_MIN, COORD_MIN, COORD_MIN));
        send_point(query_at(COORD_MAX, COORD_MAX, COORD_MAX));
        send_point(query_at(0, -1, 1));
        wait_drained();
        cfg_write(REG_SPARE_A, $urandom);
        cfg_write(REG_SPARE_B, $urandom);
        send_point(query_at(COORD_MAX, 0, COORD_MIN));          // box must be unchanged
        wait_drained();
        set_box(ONE, -ONE, 0, ONE, -ONE, 0);
        send_point(query_at(ONE, -ONE, 0));                     // all distances zero
        send_point(query_at(COORD_MIN, COORD_MAX, ONE));
        wait_drained();
        set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);               // every axis inverted
        send_point(query_at(0, 0, 0));
        send_point(query_at(COORD_MAX, COORD_MIN, ONE));
    endtask

    // Random boxes and queries under one idle/stall mix.
    task automatic test_random_traffic(int idle_pct, int out_stall_pct);
        int b;
        int n;
        for (b = 0; b < BOXES_PER_PHASE; b++) begin
            wait_drained();
            random_box();
            send_idle_pct = idle_pct;
            stall_pct     = out_stall_pct;
            for (n = 0; n < QUERIES_PER_BOX; n++) send_point(random_query());
        end
    endtask

    // Receiver holds off while the sender keeps going: the pipe fills and
    // the input must stall without losing or reordering a request.
    task automatic test_output_hold();
        int n;
        wait_drained();
        random_box();
        send_idle_pct = 0;
        stall_pct     = 0;
        out_hold_len  = HOLD_CYCLES;
        for (n = 0; n < 40; n++) send_point(random_query());
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        for (int i = 0; i < 3; i++) begin
            box_lo[i] = '0;
            box_hi[i] = ONE;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_box();
        test_box_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(82, 0);
        test_random_traffic(0, 82);
        test_random_traffic(31, 31);
        test_output_hold();

        wait_drained();
        stall_pct = 0;
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);

        $display("Ran %0d box queries (%0d results) over %0d box settings,", sent_count,
                 got_count, box_count);
        $display("with idle/stall mixes and a long output hold-off (%0d input-stall cycles).",
                 in_stall_cycles);
        if (error_count == 0 && pending_near.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count, pending_near.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
